// ----- rtl/mi3_pkg.sv -----
`default_nettype none
package mi3_pkg;

	localparam int DW = 32;
	localparam int FB = 16;

	localparam int PROD_W = 2 * DW;
	localparam int COF_W  = 2 * DW + 1;
	localparam int PART_W = 2 * DW + 1;
	localparam int TERM_W = 3 * DW + 1;
	localparam int DET_W  = 3 * DW + 3;
	localparam int CMAG_W = 2 * DW;
	localparam int DMAG_W = 3 * DW;
	localparam int NUM_W  = 2 * DW + 2 * FB;
	localparam int QW     = DW + 2;
	localparam int NSTEP  = QW;
	localparam int CMP_W  = DMAG_W + QW;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] IDENT_ONE = (FB >= DW - 1) ? SMAX : (DW'(1) << FB);

	// element indexes a, d, b, c of each cofactor a*d - b*c
	localparam int COF_IDX [9][4] = '{
		'{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
		'{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
	};
	// cofactors used in the first-row expansion of the determinant
	localparam int DET_COF [3] = '{0, 3, 6};

	typedef struct packed {
		logic                         singular;
		logic [8:0]                   neg;
		logic [DMAG_W-1:0]            dmag;
		logic [8:0][CMAG_W-1:0]       cmag;
	} mi3_work_t;

endpackage
`default_nettype wire

// ----- rtl/mi3_in_if.sv -----
`default_nettype none
interface mi3_in_if import mi3_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

	modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
	modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface
`default_nettype wire

// ----- rtl/mi3_out_if.sv -----
`default_nettype none
interface mi3_out_if import mi3_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic                 singular;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
		input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/mi3_front.sv -----
`default_nettype none
module mi3_front import mi3_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mi3_in_if.sink     mat,
	output logic       push,
	input  wire logic  full,
	output mi3_work_t  work
);

	logic signed [DW-1:0]     a [9];
	logic [5:0]               vld_s;
	logic                     en;

	logic signed [PROD_W-1:0] prod_s1 [9][2];
	logic signed [DW-1:0]     a_s1 [3];
	logic signed [COF_W-1:0]  cof_s2 [9];
	logic signed [DW-1:0]     a_s2 [3];
	logic signed [PART_W-1:0] ph_s3 [3];
	logic signed [PART_W-1:0] pl_s3 [3];
	logic signed [COF_W-1:0]  cof_s3 [9];
	logic signed [TERM_W-1:0] t_s4 [3];
	logic signed [COF_W-1:0]  cof_s4 [9];
	logic signed [DET_W-1:0]  det_s5;
	logic signed [COF_W-1:0]  cof_s5 [9];
	mi3_work_t                work_s6;
	mi3_work_t                work_nxt;
	logic [DET_W-1:0]         dabs;
	logic [COF_W-1:0]         cabs [9];

	assign a[0] = mat.a00;
	assign a[1] = mat.a01;
	assign a[2] = mat.a02;
	assign a[3] = mat.a10;
	assign a[4] = mat.a11;
	assign a[5] = mat.a12;
	assign a[6] = mat.a20;
	assign a[7] = mat.a21;
	assign a[8] = mat.a22;

	// hold the whole front while the last stage cannot drain into the queue
	assign en        = !(vld_s[5] && full);
	assign mat.ready = en;
	assign push      = vld_s[5] && !full;
	assign work      = work_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:0], mat.valid};
		end
	end

	always_comb begin
		dabs = det_s5[DET_W-1] ? DET_W'(-det_s5) : DET_W'(det_s5);
		work_nxt.singular = (det_s5 == '0);
		work_nxt.dmag     = dabs[DMAG_W-1:0];
		for (int i = 0; i < 9; i++) begin
			cabs[i] = cof_s5[i][COF_W-1] ? COF_W'(-cof_s5[i]) : COF_W'(cof_s5[i]);
			work_nxt.cmag[i] = cabs[i][CMAG_W-1:0];
			work_nxt.neg[i]  = cof_s5[i][COF_W-1] ^ det_s5[DET_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				prod_s1[i][0] <= a[COF_IDX[i][0]] * a[COF_IDX[i][1]];
				prod_s1[i][1] <= a[COF_IDX[i][2]] * a[COF_IDX[i][3]];
				cof_s2[i]     <= COF_W'(prod_s1[i][0]) - COF_W'(prod_s1[i][1]);
				cof_s3[i]     <= cof_s2[i];
				cof_s4[i]     <= cof_s3[i];
				cof_s5[i]     <= cof_s4[i];
			end
			for (int j = 0; j < 3; j++) begin
				a_s1[j]  <= a[j];
				a_s2[j]  <= a_s1[j];
				// split the cofactor at DW bits to keep each multiply near DW x DW
				ph_s3[j] <= a_s2[j] * $signed(cof_s2[DET_COF[j]][COF_W-1:DW]);
				pl_s3[j] <= a_s2[j] * $signed({1'b0, cof_s2[DET_COF[j]][DW-1:0]});
				t_s4[j]  <= (TERM_W'(ph_s3[j]) <<< DW) + TERM_W'(pl_s3[j]);
			end
			det_s5  <= DET_W'(t_s4[0]) + DET_W'(t_s4[1]) + DET_W'(t_s4[2]);
			work_s6 <= work_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mi3_fifo.sv -----
`default_nettype none
module mi3_fifo import mi3_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mi3_work_t      din,
	output logic                full,
	input  wire logic           pop,
	output mi3_work_t           dout,
	output logic                empty,
	output logic [FIFO_AW:0]    count
);

	mi3_work_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wr_q;
	logic [FIFO_AW-1:0]     rd_q;
	logic [FIFO_AW:0]       cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mi3_back.sv -----
`default_nettype none
module mi3_back import mi3_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       empty,
	input  wire mi3_work_t  work,
	output logic            pop,
	mi3_out_if.source       inv
);

	logic                     en;
	logic [NSTEP:0]           vld_s;
	logic [NUM_W-1:0]         rem_s [NSTEP+1][9];
	logic [QW-1:0]            q_s [NSTEP+1][9];
	logic [DMAG_W-1:0]        dmag_s [NSTEP+1];
	logic [8:0]               neg_s [NSTEP+1];
	logic                     sing_s [NSTEP+1];

	logic [CMP_W-1:0]         dsh [NSTEP];
	logic                     ge [NSTEP][9];
	logic [CMP_W-1:0]         diff [NSTEP][9];

	logic [QW:0]              qr [9];
	logic                     rnd [9];
	logic [DW-1:0]            res [9];
	logic [DW-1:0]            out_q [9];
	logic                     out_sing_q;
	logic                     out_vld_q;

	assign en  = !out_vld_q || inv.ready;
	assign pop = en && !empty;

	// one quotient bit per stage, most significant first
	always_comb begin
		for (int i = 0; i < NSTEP; i++) begin
			dsh[i] = CMP_W'(dmag_s[i]) << (NSTEP - 1 - i);
			for (int l = 0; l < 9; l++) begin
				diff[i][l] = CMP_W'(rem_s[i][l]) - dsh[i];
				ge[i][l]   = CMP_W'(rem_s[i][l]) >= dsh[i];
			end
		end
	end

	// round half away from zero on the magnitude, then saturate; a singular matrix gives the identity
	always_comb begin
		for (int l = 0; l < 9; l++) begin
			rnd[l] = CMP_W'({rem_s[NSTEP][l], 1'b0}) >= CMP_W'(dmag_s[NSTEP]);
			qr[l]  = (QW+1)'(q_s[NSTEP][l]) + (QW+1)'(rnd[l]);
			if (sing_s[NSTEP]) begin
				res[l] = (l == 0 || l == 4 || l == 8) ? IDENT_ONE : '0;
			end else if (!neg_s[NSTEP][l]) begin
				res[l] = (qr[l] > (QW+1)'(SMAX)) ? SMAX : qr[l][DW-1:0];
			end else begin
				res[l] = (qr[l] > (QW+1)'(SMIN)) ? SMIN : DW'(-qr[l][DW-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[NSTEP-1:0], pop};
			out_vld_q <= vld_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 9; l++) begin
				rem_s[0][l] <= NUM_W'(work.cmag[l]) << (2 * FB);
				q_s[0][l]   <= '0;
			end
			dmag_s[0] <= work.dmag;
			neg_s[0]  <= work.neg;
			sing_s[0] <= work.singular;
			for (int i = 0; i < NSTEP; i++) begin
				for (int l = 0; l < 9; l++) begin
					rem_s[i+1][l] <= ge[i][l] ? diff[i][l][NUM_W-1:0] : rem_s[i][l];
					q_s[i+1][l]   <= {q_s[i][l][QW-2:0], ge[i][l]};
				end
				dmag_s[i+1] <= dmag_s[i];
				neg_s[i+1]  <= neg_s[i];
				sing_s[i+1] <= sing_s[i];
			end
			for (int l = 0; l < 9; l++) begin
				out_q[l] <= res[l];
			end
			out_sing_q <= sing_s[NSTEP];
		end
	end

	assign inv.valid    = out_vld_q;
	assign inv.r00      = out_q[0];
	assign inv.r01      = out_q[1];
	assign inv.r02      = out_q[2];
	assign inv.r10      = out_q[3];
	assign inv.r11      = out_q[4];
	assign inv.r12      = out_q[5];
	assign inv.r20      = out_q[6];
	assign inv.r21      = out_q[7];
	assign inv.r22      = out_q[8];
	assign inv.singular = out_sing_q;

endmodule
`default_nettype wire

// ----- rtl/matrix3x3_inverse.sv -----
`default_nettype none
// Channel | Dir | Payload                          | Handshake
// mat     | in  | a00..a22, signed Q16.16          | valid/ready
// inv     | out | r00..r22 Q16.16 sat, singular    | valid/ready
//
// One matrix per cycle sustained while nothing stalls; a matrix passes through six front
// stages (the first loads at the accepting edge), the queue, the divider input register,
// 34 restoring-divide stages that each resolve one quotient bit for all nine lanes, and
// the rounding/saturation register.
// Reset clears all valid bits and the queue pointers; data registers are not reset.
// A stalled output holds the back pipeline; the front keeps going into the
// four-entry queue and holds only once the queue is full.
module matrix3x3_inverse import mi3_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mi3_in_if.sink    mat,
	mi3_out_if.source inv
);

	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	logic [FIFO_AW:0]   count;
	mi3_work_t          work_in;
	mi3_work_t          work_out;

	mi3_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat),
		.push   (push),
		.full   (full),
		.work   (work_in)
	);

	mi3_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (work_in),
		.full   (full),
		.pop    (pop),
		.dout   (work_out),
		.empty  (empty),
		.count  (count)
	);

	mi3_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.work   (work_out),
		.pop    (pop),
		.inv    (inv)
	);

	a_singular_identity: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && inv.singular |-> inv.r00 == IDENT_ONE && inv.r11 == IDENT_ONE &&
		inv.r22 == IDENT_ONE && inv.r01 == '0 && inv.r02 == '0 && inv.r10 == '0 &&
		inv.r12 == '0 && inv.r20 == '0 && inv.r21 == '0)
		else $error("singular result is not the identity");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("queue occupancy out of range");

	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count == $past(count) + 1'b1)
		else $error("queue count did not follow a lone write");

	a_queue_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count == $past(count) - 1'b1)
		else $error("queue count did not follow a lone read");

endmodule
`default_nettype wire

// ----- tb/sv/matrix3x3_inverse_tb.sv -----
`timescale 1ns / 100ps
module matrix3x3_inverse_tb;
	import mi3_pkg::*;

	typedef logic signed [DW-1:0] elem_t;

	typedef struct {
		elem_t a [9];
	} matrix_t;

	typedef struct {
		elem_t r [9];
		logic  singular;
	} inverse_t;

	logic clk;
	logic arst_n;
	int   fail_cnt;
	int   cycle_cnt;
	bit   hold_idle;

	mi3_in_if  mat ();
	mi3_out_if inv ();

	matrix3x3_inverse dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat),
		.inv    (inv)
	);

	inverse_t expected_q [$];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// round(num / den), ties away from zero, saturated to DW bits
	function automatic elem_t quotient_sat(logic signed [255:0] num, logic signed [255:0] den);
		logic [255:0] nm;
		logic [255:0] dm;
		logic [255:0] q;
		logic [255:0] rem;
		bit           neg;
		neg = (num < 0) != (den < 0);
		nm  = (num < 0) ? -num : num;
		dm  = (den < 0) ? -den : den;
		q   = nm / dm;
		rem = nm % dm;
		if ((rem << 1) >= dm)
			q = q + 1;
		if (!neg)
			return (q > 256'(SMAX)) ? SMAX : elem_t'(q);
		if (q > 256'(SMAX) + 1)
			return SMIN;
		return elem_t'(-q);
	endfunction

	function automatic inverse_t invert(matrix_t m);
		logic signed [255:0] e [9];
		logic signed [255:0] cf [9];
		logic signed [255:0] det;
		inverse_t            res;
		for (int i = 0; i < 9; i++)
			e[i] = m.a[i];
		for (int i = 0; i < 9; i++)
			cf[i] = e[COF_IDX[i][0]] * e[COF_IDX[i][1]] - e[COF_IDX[i][2]] * e[COF_IDX[i][3]];
		det = e[0] * cf[0] + e[1] * cf[3] + e[2] * cf[6];
		res.singular = (det == 0);
		for (int i = 0; i < 9; i++) begin
			if (res.singular)
				res.r[i] = (i % 4 == 0) ? IDENT_ONE : '0;
			else
				res.r[i] = quotient_sat(cf[i] <<< (2 * FB), det);
		end
		return res;
	endfunction

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 5))
			0: return elem_t'($urandom());
			1: return elem_t'($urandom_range(0, 1) ? SMAX : SMIN);
			2: return elem_t'(int'($urandom_range(0, 8)) - 4) <<< FB;
			3: return elem_t'(int'($urandom_range(0, 2048)) - 1024);
			default: return elem_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic matrix_t rand_matrix();
		matrix_t m;
		int      src;
		int      dst;
		bit      by_row;
		for (int i = 0; i < 9; i++)
			m.a[i] = rand_elem();
		// copy a row or column now and then to hit singular matrices
		if ($urandom_range(0, 9) == 0) begin
			src    = $urandom_range(0, 2);
			dst    = (src + 1) % 3;
			by_row = $urandom_range(0, 1);
			for (int k = 0; k < 3; k++)
				if (by_row)
					m.a[dst * 3 + k] = m.a[src * 3 + k];
				else
					m.a[k * 3 + dst] = m.a[k * 3 + src];
		end
		return m;
	endfunction

	function automatic bit idle_now();
		return !hold_idle && ($urandom_range(0, 99) < 21);
	endfunction

	task automatic send(matrix_t m, bit has_typed, inverse_t typed);
		inverse_t pred;
		bit       differ;
		while (idle_now()) begin
			mat.valid <= 1'b0;
			@(negedge clk);
		end
		pred   = invert(m);
		differ = (pred.singular !== typed.singular);
		for (int i = 0; i < 9; i++)
			if (pred.r[i] !== typed.r[i])
				differ = 1'b1;
		if (has_typed && differ) begin
			$error("typed row disagrees with prediction");
			fail_cnt++;
		end
		mat.valid <= 1'b1;
		{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12, mat.a20, mat.a21, mat.a22}
			<= {m.a[0], m.a[1], m.a[2], m.a[3], m.a[4], m.a[5], m.a[6], m.a[7], m.a[8]};
		@(posedge clk);
		while (!mat.ready)
			@(posedge clk);
		expected_q.push_back(has_typed ? typed : pred);
		@(negedge clk);
	endtask

	function automatic matrix_t diag(elem_t x, elem_t y, elem_t z);
		matrix_t m;
		foreach (m.a[i])
			m.a[i] = '0;
		m.a[0] = x;
		m.a[4] = y;
		m.a[8] = z;
		return m;
	endfunction

	function automatic inverse_t diag_inv(elem_t x, elem_t y, elem_t z, logic sing);
		inverse_t r;
		foreach (r.r[i])
			r.r[i] = '0;
		r.r[0] = x;
		r.r[4] = y;
		r.r[8] = z;
		r.singular = sing;
		return r;
	endfunction

	localparam elem_t ONE = elem_t'(1) <<< FB;

	typedef struct {
		matrix_t  m;
		bit       has_typed;
		inverse_t typed;
	} stim_row_t;

	stim_row_t stim_table [$];

	task automatic build_table();
		stim_row_t row;
		matrix_t   m;
		row.has_typed = 1'b1;
		// identity and zero
		row.m = diag(ONE, ONE, ONE);       row.typed = diag_inv(ONE, ONE, ONE, 1'b0);
		stim_table.push_back(row);
		row.m = diag('0, '0, '0);          row.typed = diag_inv(ONE, ONE, ONE, 1'b1);
		stim_table.push_back(row);
		row.m = diag(ONE, '0, ONE);        row.typed = diag_inv(ONE, ONE, ONE, 1'b1);
		stim_table.push_back(row);
		// 2, -1, 4 on the diagonal
		row.m = diag(2 * ONE, -ONE, 4 * ONE);
		row.typed = diag_inv(ONE / 2, -ONE, ONE / 4, 1'b0);
		stim_table.push_back(row);
		// tiny diagonal: quotient far too large, both signs
		row.m = diag(elem_t'(1), elem_t'(-1), elem_t'(1));
		row.typed = diag_inv(SMAX, SMIN, SMAX, 1'b0);
		stim_table.push_back(row);
		// extreme elements on the diagonal: 1 / -32768 is two codes below zero
		row.m = diag(SMIN, SMIN, SMIN);
		row.typed = diag_inv(elem_t'(-2), elem_t'(-2), elem_t'(-2), 1'b0);
		stim_table.push_back(row);
		// predicted from here on: tiny, full-scale and whole-unit diagonals
		row.has_typed = 1'b0;
		row.m = diag(elem_t'(3), elem_t'(-3), elem_t'(5));
		stim_table.push_back(row);
		row.m = diag(SMAX, SMAX, SMAX);
		stim_table.push_back(row);
		row.m = diag(elem_t'(1 << 17), elem_t'(-(1 << 17)), elem_t'(3 << 16));
		stim_table.push_back(row);
		// all elements equal: singular, plus full extremes
		foreach (m.a[i])
			m.a[i] = SMAX;
		row.m = m;
		stim_table.push_back(row);
		foreach (m.a[i])
			m.a[i] = (i % 2) ? SMIN : SMAX;
		row.m = m;
		stim_table.push_back(row);
		foreach (m.a[i])
			m.a[i] = elem_t'(-1);
		row.m = m;
		stim_table.push_back(row);
		// general dense matrices
		m.a = '{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 0};
		row.m = m;
		stim_table.push_back(row);
		m.a = '{SMIN, SMAX, elem_t'(1), elem_t'(-1), SMIN, SMAX, SMAX, elem_t'(0), SMIN};
		row.m = m;
		stim_table.push_back(row);
		m.a = '{elem_t'(7), elem_t'(-2), elem_t'(3), elem_t'(1), elem_t'(5), elem_t'(-4),
			elem_t'(2), elem_t'(9), elem_t'(1)};
		row.m = m;
		stim_table.push_back(row);
	endtask

	// result side: random back-pressure, compare in order
	always @(negedge clk) begin
		if (arst_n)
			inv.ready <= !idle_now();
	end

	always @(posedge clk) begin
		inverse_t exp_res;
		elem_t    got [9];
		if (arst_n && inv.valid && inv.ready) begin
			got = '{inv.r00, inv.r01, inv.r02, inv.r10, inv.r11, inv.r12,
				inv.r20, inv.r21, inv.r22};
			if (expected_q.size() == 0) begin
				$error("inverse transaction with nothing expected");
				fail_cnt++;
			end else begin
				exp_res = expected_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== exp_res.r[i]) begin
						$error("r%0d%0d expected %0d actual %0d", i / 3, i % 3,
							exp_res.r[i], got[i]);
						fail_cnt++;
					end
				if (inv.singular !== exp_res.singular) begin
					$error("singular expected %0b actual %0b", exp_res.singular,
						inv.singular);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > 400000) begin
			$display("matrix3x3_inverse_tb: errors");
			$finish;
		end
	end

	initial begin
		int     tail;
		fail_cnt  = 0;
		cycle_cnt = 0;
		hold_idle = 1'b0;
		arst_n    = 1'b0;
		mat.valid = 1'b0;
		{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12, mat.a20, mat.a21, mat.a22} = '0;
		inv.ready = 1'b0;
		build_table();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[i])
			send(stim_table[i].m, stim_table[i].has_typed, stim_table[i].typed);

		for (int n = 0; n < 1100; n++) begin
			// no idling on either side for a stretch
			hold_idle = (n >= 300 && n < 500);
			// drain fully once mid-run
			if (n == 600) begin
				mat.valid <= 1'b0;
				@(negedge clk);
				while (expected_q.size() != 0)
					@(negedge clk);
			end
			send(rand_matrix(), 1'b0, diag_inv('0, '0, '0, 1'b0));
		end
		hold_idle = 1'b0;
		mat.valid <= 1'b0;

		while (expected_q.size() != 0)
			@(negedge clk);
		tail = 0;
		while (tail < 100) begin
			@(negedge clk);
			tail++;
		end
		if (fail_cnt == 0)
			$display("matrix3x3_inverse_tb: clean");
		else
			$display("matrix3x3_inverse_tb: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/mi3_pkg.sv
rtl/mi3_in_if.sv
rtl/mi3_out_if.sv
rtl/mi3_front.sv
rtl/mi3_fifo.sv
rtl/mi3_back.sv
rtl/matrix3x3_inverse.sv
tb/sv/matrix3x3_inverse_tb.sv
